// ===== design/mpbd_pkg.sv =====
package mpbd_pkg;

   localparam int MaxWidth   = 128;
   localparam int MaxHeight  = 64;
   localparam int StoreBytes = (MaxWidth * MaxHeight) / 8;
   localparam int AddrW      = $clog2(StoreBytes);
   localparam int DimW       = 9;
   localparam int CoordW     = 12;
   localparam int LineW      = 16;
   localparam int ModeW      = 3;
   localparam int IdxW       = 10;
   localparam int DataW      = 8;
   localparam int CsrAddrW   = 3;
   localparam int CsrDataW   = 32;

   typedef enum logic [ModeW-1:0] {
      MODE_LINE,
      MODE_MOVE,
      MODE_LINE_TO,
      MODE_RECT,
      MODE_FILL,
      MODE_CLEAR_RECT,
      MODE_CLEAR_ALL,
      MODE_READ
   } mode_type;

   localparam logic CSR_SEL_WIDTH  = 1'b0;
   localparam logic CSR_SEL_HEIGHT = 1'b1;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      logic [DataW-1:0] data;
   } wr_port_type;

endpackage

// ===== design/mpbd_ifs.sv =====
interface mpbd_req_if;
   import mpbd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [ModeW-1:0]         mode;
   logic signed [CoordW-1:0] x_a;
   logic signed [CoordW-1:0] y_a;
   logic signed [CoordW-1:0] x_b;
   logic signed [CoordW-1:0] y_b;
   logic [IdxW-1:0]          byte_index;
   modport source (output valid, mode, x_a, y_a, x_b, y_b, byte_index, input ready);
   modport sink (input valid, mode, x_a, y_a, x_b, y_b, byte_index, output ready);
endinterface

interface mpbd_rsp_if;
   import mpbd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [DataW-1:0]         read_data;
   logic signed [CoordW-1:0] current_pen_x;
   logic signed [CoordW-1:0] current_pen_y;
   modport source (output valid, read_data, current_pen_x, current_pen_y, input ready);
   modport sink (input valid, read_data, current_pen_x, current_pen_y, output ready);
endinterface

// ===== design/mpbd_store.sv =====
module mpbd_store (
   input  logic                         clock,
   input  logic [mpbd_pkg::AddrW-1:0]   rd_addr,
   output logic [mpbd_pkg::DataW-1:0]   rd_data,
   input  mpbd_pkg::wr_port_type        wr
);
   import mpbd_pkg::*;

   logic [DataW-1:0] mem [StoreBytes];
   logic [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mono_page_bitmap_line_rect_drawer.sv =====
// Operation: a line steps pixel by pixel and skips pixels off the bitmap, a rectangle
//   outline draws its four sides the same way, fill/clear visit each pixel of the
//   clipped area, clear all clears one byte per cycle. One transaction in
//   flight; each plotted pixel is a read-modify-write through the frame store's
//   read and write ports, which sets the rate.
// Reset: synchronous; a clearing pass writes zero to all 1024 bytes of the frame
//   store; no transaction is accepted until it ends. Width 128, height 64, pen at origin.
module mono_page_bitmap_line_rect_drawer (
   input  logic                            clock,
   input  logic                            reset,
   mpbd_req_if.sink                        req_if,
   mpbd_rsp_if.source                      rsp_if,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mpbd_pkg::CsrAddrW-1:0]   paddr,
   input  logic [mpbd_pkg::CsrDataW-1:0]   pwdata,
   output logic [mpbd_pkg::CsrDataW-1:0]   prdata,
   output logic                            pready
);
   import mpbd_pkg::*;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_LSETUP, S_LSTEP, S_FILL, S_WIPE, S_RMW, S_READ, S_DONE
   } state_type;

   typedef logic signed [LineW-1:0] lc_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [7:0] width_ff, width_in;
   logic [6:0] height_ff, height_in;
   logic signed [CoordW-1:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   lc_type ls_x_ff, ls_x_in, ls_y_ff, ls_y_in, le_x_ff, le_x_in, le_y_ff, le_y_in;
   lc_type r_x1_ff, r_x1_in, r_y1_ff, r_y1_in, r_x2_ff, r_x2_in, r_y2_ff, r_y2_in;
   lc_type cx_ff, cx_in, cy_ff, cy_in, dx_ff, dx_in, dy_ff, dy_in, n_ff, n_in;
   logic signed [LineW:0] err_ff, err_in;
   logic sxn_ff, sxn_in, syn_ff, syn_in, xmaj_ff, xmaj_in, rect_ff, rect_in;
   logic set_ff, set_in;
   logic [1:0] seg_ff, seg_in;
   logic [DimW-1:0] fx_ff, fx_in, fy_ff, fy_in, fx2_ff, fx2_in, fy1_ff, fy1_in;
   logic [DimW-1:0] fy2_ff, fy2_in;
   logic [AddrW:0] cnt_ff, cnt_in, lim_ff, lim_in;
   logic [AddrW-1:0] pend_addr_ff, pend_addr_in;
   logic [DataW-1:0] pend_mask_ff, pend_mask_in, res_data_ff, res_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0] rsp_data_ff, rsp_data_in;
   logic signed [CoordW-1:0] rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;

   logic [DimW-1:0] ew, eh;
   lc_type px, py, xs, ys, xe, ye, nx, ny;
   logic [LineW-1:0] addr_full;
   logic pix_ok;
   logic [DataW-1:0] pix_mask;
   logic signed [LineW:0] e1, e2;
   logic [AddrW-1:0] rd_addr;
   logic [DataW-1:0] rd_data;
   wr_port_type wr;
   logic signed [CoordW-1:0] sx1, sx2, sy1, sy2;
   logic [2*DimW-1:0] area;
   logic [LineW-1:0] idx_ext;
   logic csr_wr;

   function automatic logic [DimW-1:0] clip_dim(logic signed [CoordW-1:0] v,
                                                 logic [DimW-1:0] hi);
      lc_type vv;
      vv = LineW'(v);
      if (vv < 0) return '0;
      if (vv > $signed(LineW'(hi))) return hi;
      return vv[DimW-1:0];
   endfunction

   mpbd_store u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   assign ew = (DimW'(width_ff) > DimW'(MaxWidth)) ? DimW'(MaxWidth) : DimW'(width_ff);
   assign eh = (DimW'(height_ff) > DimW'(MaxHeight)) ? DimW'(MaxHeight) : DimW'(height_ff);

   assign px = (state_ff == S_FILL) ? LineW'(fx_ff) : cx_ff;
   assign py = (state_ff == S_FILL) ? LineW'(fy_ff) : cy_ff;
   assign addr_full = LineW'(py[DimW-2:3]) * LineW'(ew) + LineW'(px[DimW-1:0]);
   assign pix_ok = (px >= 0) && (py >= 0) && (px < $signed(LineW'(ew)))
                   && (py < $signed(LineW'(eh))) && (addr_full < LineW'(StoreBytes));
   assign pix_mask = DataW'(1) << py[2:0];

   assign idx_ext = LineW'(req_if.byte_index);
   assign rd_addr = (state_ff == S_IDLE) ? idx_ext[AddrW-1:0] : addr_full[AddrW-1:0];

   assign sx1 = (req_if.x_a > req_if.x_b) ? req_if.x_b : req_if.x_a;
   assign sx2 = (req_if.x_a > req_if.x_b) ? req_if.x_a : req_if.x_b;
   assign sy1 = (req_if.y_a > req_if.y_b) ? req_if.y_b : req_if.y_a;
   assign sy2 = (req_if.y_a > req_if.y_b) ? req_if.y_a : req_if.y_b;
   assign area = ew * eh;

   always_comb begin
      xs = ls_x_ff;
      ys = ls_y_ff;
      xe = le_x_ff;
      ye = le_y_ff;
      if (rect_ff) begin
         case (seg_ff)
            2'd0: begin xs = r_x1_ff; ys = r_y1_ff; xe = r_x2_ff; ye = r_y1_ff; end
            2'd1: begin xs = r_x2_ff; ys = r_y1_ff; xe = r_x2_ff; ye = r_y2_ff; end
            2'd2: begin xs = r_x2_ff; ys = r_y2_ff; xe = r_x1_ff; ye = r_y2_ff; end
            default: begin xs = r_x1_ff; ys = r_y2_ff; xe = r_x1_ff; ye = r_y1_ff; end
         endcase
      end
   end

   always_comb begin
      nx = cx_ff;
      ny = cy_ff;
      e1 = '0;
      e2 = '0;
      if (xmaj_ff) begin
         nx = sxn_ff ? cx_ff - lc_type'(1) : cx_ff + lc_type'(1);
         e1 = err_ff + (LineW+1)'(dy_ff);
         e2 = e1;
         if (e1 >= 0) begin
            ny = syn_ff ? cy_ff - lc_type'(1) : cy_ff + lc_type'(1);
            e2 = e1 - (LineW+1)'(dx_ff);
         end
      end else begin
         ny = syn_ff ? cy_ff - lc_type'(1) : cy_ff + lc_type'(1);
         e1 = err_ff + (LineW+1)'(dx_ff);
         e2 = e1;
         if (e1 >= 0) begin
            nx = sxn_ff ? cx_ff - lc_type'(1) : cx_ff + lc_type'(1);
            e2 = e1 - (LineW+1)'(dy_ff);
         end
      end
   end

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = paddr[2] ? CsrDataW'(height_ff) : CsrDataW'(width_ff);

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      width_in = width_ff;
      height_in = height_ff;
      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      ls_x_in = ls_x_ff;
      ls_y_in = ls_y_ff;
      le_x_in = le_x_ff;
      le_y_in = le_y_ff;
      r_x1_in = r_x1_ff;
      r_y1_in = r_y1_ff;
      r_x2_in = r_x2_ff;
      r_y2_in = r_y2_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      n_in = n_ff;
      err_in = err_ff;
      sxn_in = sxn_ff;
      syn_in = syn_ff;
      xmaj_in = xmaj_ff;
      rect_in = rect_ff;
      set_in = set_ff;
      seg_in = seg_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      fx2_in = fx2_ff;
      fy1_in = fy1_ff;
      fy2_in = fy2_ff;
      cnt_in = cnt_ff;
      lim_in = lim_ff;
      pend_addr_in = pend_addr_ff;
      pend_mask_in = pend_mask_ff;
      res_data_in = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in = rsp_data_ff;
      rsp_px_in = rsp_px_ff;
      rsp_py_in = rsp_py_ff;
      wr = '0;
      req_if.ready = (state_ff == S_IDLE);

      if (csr_wr) begin
         if (paddr[2] == CSR_SEL_HEIGHT) height_in = pwdata[6:0];
         else width_in = pwdata[7:0];
      end

      case (state_ff)
         S_CLR: begin
            wr.en = 1'b1;
            wr.addr = cnt_ff[AddrW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AddrW+1)'(StoreBytes - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_if.valid) begin
               res_data_in = '0;
               set_in = 1'b1;
               rect_in = 1'b0;
               seg_in = '0;
               case (mode_type'(req_if.mode))
                  MODE_LINE: begin
                     ls_x_in = LineW'(req_if.x_a);
                     ls_y_in = LineW'(req_if.y_a);
                     le_x_in = LineW'(req_if.x_b);
                     le_y_in = LineW'(req_if.y_b);
                     state_in = S_LSETUP;
                  end
                  MODE_MOVE: begin
                     pen_x_in = req_if.x_b;
                     pen_y_in = req_if.y_b;
                     state_in = S_DONE;
                  end
                  MODE_LINE_TO: begin
                     ls_x_in = LineW'(pen_x_ff);
                     ls_y_in = LineW'(pen_y_ff);
                     le_x_in = LineW'(req_if.x_b);
                     le_y_in = LineW'(req_if.y_b);
                     pen_x_in = req_if.x_b;
                     pen_y_in = req_if.y_b;
                     state_in = S_LSETUP;
                  end
                  MODE_RECT: begin
                     r_x1_in = LineW'(sx1);
                     r_y1_in = LineW'(sy1);
                     r_x2_in = LineW'(sx2) - lc_type'(1);
                     r_y2_in = LineW'(sy2) - lc_type'(1);
                     rect_in = 1'b1;
                     state_in = S_LSETUP;
                  end
                  MODE_FILL, MODE_CLEAR_RECT: begin
                     set_in = (mode_type'(req_if.mode) == MODE_FILL);
                     fx_in = clip_dim(sx1, ew);
                     fx2_in = clip_dim(sx2, ew);
                     fy_in = clip_dim(sy1, eh);
                     fy1_in = clip_dim(sy1, eh);
                     fy2_in = clip_dim(sy2, eh);
                     state_in = S_FILL;
                  end
                  MODE_CLEAR_ALL: begin
                     cnt_in = '0;
                     lim_in = ((area >> 3) > (2*DimW)'(StoreBytes)) ?
                              (AddrW+1)'(StoreBytes) : (AddrW+1)'(area >> 3);
                     state_in = S_WIPE;
                  end
                  MODE_READ: begin
                     set_in = (idx_ext < LineW'(StoreBytes));
                     state_in = S_READ;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_LSETUP: begin
            cx_in = xs;
            cy_in = ys;
            sxn_in = !(xe > xs);
            syn_in = !(ye > ys);
            dx_in = (xe > xs) ? xe - xs : xs - xe;
            dy_in = (ye > ys) ? ye - ys : ys - ye;
            xmaj_in = (dx_in > dy_in);
            n_in = xmaj_in ? dx_in : dy_in;
            err_in = -((LineW+1)'(n_in));
            state_in = S_LSTEP;
         end
         S_LSTEP: begin
            if (n_ff == 0) begin
               if (rect_ff && seg_ff != 2'd3) begin
                  seg_in = seg_ff + 1'b1;
                  state_in = S_LSETUP;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cx_in = nx;
               cy_in = ny;
               err_in = e2;
               n_in = n_ff - lc_type'(1);
               if (pix_ok) begin
                  pend_addr_in = addr_full[AddrW-1:0];
                  pend_mask_in = pix_mask;
                  ret_in = S_LSTEP;
                  state_in = S_RMW;
               end
            end
         end
         S_FILL: begin
            if (fx_ff >= fx2_ff || fy1_ff >= fy2_ff) begin
               state_in = S_DONE;
            end else begin
               if (fy_ff + 1'b1 >= fy2_ff) begin
                  fy_in = fy1_ff;
                  fx_in = fx_ff + 1'b1;
               end else begin
                  fy_in = fy_ff + 1'b1;
               end
               if (pix_ok) begin
                  pend_addr_in = addr_full[AddrW-1:0];
                  pend_mask_in = pix_mask;
                  ret_in = S_FILL;
                  state_in = S_RMW;
               end
            end
         end
         S_RMW: begin
            wr.en = 1'b1;
            wr.addr = pend_addr_ff;
            wr.data = set_ff ? (rd_data | pend_mask_ff) : (rd_data & ~pend_mask_ff);
            state_in = ret_ff;
         end
         S_WIPE: begin
            if (cnt_ff == lim_ff) begin
               state_in = S_DONE;
            end else begin
               wr.en = 1'b1;
               wr.addr = cnt_ff[AddrW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_READ: begin
            res_data_in = set_ff ? rd_data : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_data_ff;
               rsp_px_in = pen_x_ff;
               rsp_py_in = pen_y_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         ret_ff <= S_IDLE;
         width_ff <= 8'(MaxWidth);
         height_ff <= 7'(MaxHeight);
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         width_ff <= width_in;
         height_ff <= height_in;
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ls_x_ff <= ls_x_in;
      ls_y_ff <= ls_y_in;
      le_x_ff <= le_x_in;
      le_y_ff <= le_y_in;
      r_x1_ff <= r_x1_in;
      r_y1_ff <= r_y1_in;
      r_x2_ff <= r_x2_in;
      r_y2_ff <= r_y2_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      n_ff <= n_in;
      err_ff <= err_in;
      sxn_ff <= sxn_in;
      syn_ff <= syn_in;
      xmaj_ff <= xmaj_in;
      rect_ff <= rect_in;
      set_ff <= set_in;
      seg_ff <= seg_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fx2_ff <= fx2_in;
      fy1_ff <= fy1_in;
      fy2_ff <= fy2_in;
      lim_ff <= lim_in;
      pend_addr_ff <= pend_addr_in;
      pend_mask_ff <= pend_mask_in;
      res_data_ff <= res_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_px_ff <= rsp_px_in;
      rsp_py_ff <= rsp_py_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;
   assign rsp_if.current_pen_x = rsp_px_ff;
   assign rsp_if.current_pen_y = rsp_py_ff;

endmodule

// ===== tb/tb_mono_page_bitmap_line_rect_drawer.sv =====
`timescale 1ns / 100ps

module tb_mono_page_bitmap_line_rect_drawer;
   import mpbd_pkg::*;

   localparam int WatchLimit = 80000;
   localparam logic [CsrAddrW-1:0] AddrWidth  = {CSR_SEL_WIDTH, 2'b00};
   localparam logic [CsrAddrW-1:0] AddrHeight = {CSR_SEL_HEIGHT, 2'b00};

   typedef struct {
      mode_type mode;
      int       xa, ya, xb, yb;
      int       idx;
      bit       chk;
      int       rd, px, py;
   } cmd_type;

   typedef struct {
      logic [DataW-1:0]  rd;
      logic [CoordW-1:0] px, py;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CsrAddrW-1:0] paddr = '0;
   logic [CsrDataW-1:0] pwdata = '0;
   logic [CsrDataW-1:0] prdata;
   logic pready;

   mpbd_req_if req_if ();
   mpbd_rsp_if rsp_if ();

   mono_page_bitmap_line_rect_drawer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [7:0] pix_mem [StoreBytes];
   int pen_x, pen_y, reg_w, reg_h;
   result_type pending[$];
   int errors, quiet_cycles, n_sent, n_seen;
   bit calm;
   cmd_type cur;
   cmd_type plan[$];

   function automatic void plot(int x, int y);
      int w, h, a;
      w = (reg_w > MaxWidth) ? MaxWidth : reg_w;
      h = (reg_h > MaxHeight) ? MaxHeight : reg_h;
      if (x < 0 || y < 0 || x >= w || y >= h) return;
      a = (y / 8) * w + x;
      if (a < StoreBytes) pix_mem[a][y % 8] = 1'b1;
   endfunction

   function automatic void trace(int xs, int ys, int xe, int ye);
      int sx, sy, dx, dy, err, cx, cy;
      cx = xs;
      cy = ys;
      if (xe > xs) begin sx = 1; dx = xe - xs; end else begin sx = -1; dx = xs - xe; end
      if (ye > ys) begin sy = 1; dy = ye - ys; end else begin sy = -1; dy = ys - ye; end
      if (dx > dy) begin
         err = -dx;
         for (int n = dx; n > 0; n--) begin
            plot(cx, cy);
            cx += sx;
            err += dy;
            if (err >= 0) begin cy += sy; err -= dx; end
         end
      end else begin
         err = -dy;
         for (int n = dy; n > 0; n--) begin
            plot(cx, cy);
            cy += sy;
            err += dx;
            if (err >= 0) begin cx += sx; err -= dy; end
         end
      end
   endfunction

   function automatic int clamp(int v, int hi);
      return (v < 0) ? 0 : (v > hi) ? hi : v;
   endfunction

   function automatic void paint(int x1, int y1, int x2, int y2, bit set);
      int t, w, h, a;
      w = (reg_w > MaxWidth) ? MaxWidth : reg_w;
      h = (reg_h > MaxHeight) ? MaxHeight : reg_h;
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      x1 = clamp(x1, w); x2 = clamp(x2, w);
      y1 = clamp(y1, h); y2 = clamp(y2, h);
      for (int x = x1; x < x2; x++)
         for (int y = y1; y < y2; y++) begin
            a = (y / 8) * w + x;
            if (a < StoreBytes) pix_mem[a][y % 8] = set;
         end
   endfunction

   function automatic result_type render(cmd_type c);
      result_type r;
      int x1, y1, x2, y2, t, n;
      x1 = c.xa; y1 = c.ya; x2 = c.xb; y2 = c.yb;
      r.rd = '0;
      case (c.mode)
         MODE_LINE: trace(x1, y1, x2, y2);
         MODE_MOVE: begin pen_x = x2; pen_y = y2; end
         MODE_LINE_TO: begin
            trace(pen_x, pen_y, x2, y2);
            pen_x = x2;
            pen_y = y2;
         end
         MODE_RECT: begin
            if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
            if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
            trace(x1, y1, x2 - 1, y1);
            trace(x2 - 1, y1, x2 - 1, y2 - 1);
            trace(x2 - 1, y2 - 1, x1, y2 - 1);
            trace(x1, y2 - 1, x1, y1);
         end
         MODE_FILL: paint(x1, y1, x2, y2, 1'b1);
         MODE_CLEAR_RECT: paint(x1, y1, x2, y2, 1'b0);
         MODE_CLEAR_ALL: begin
            n = (((reg_w > MaxWidth) ? MaxWidth : reg_w) *
                 ((reg_h > MaxHeight) ? MaxHeight : reg_h)) / 8;
            for (int i = 0; i < n && i < StoreBytes; i++) pix_mem[i] = '0;
         end
         default: r.rd = pix_mem[c.idx];
      endcase
      r.px = pen_x[CoordW-1:0];
      r.py = pen_y[CoordW-1:0];
      return r;
   endfunction

   function automatic void row(mode_type m, int xa, int ya, int xb, int yb, int idx,
                               bit chk = 0, int rd = 0, int px = 0, int py = 0);
      cmd_type c;
      c = '{m, xa, ya, xb, yb, idx, chk, rd, px, py};
      plan.push_back(c);
   endfunction

   function automatic int coord(int span);
      int p;
      p = $urandom_range(99);
      if (p < 80) return $urandom_range(span + 8) - 8;
      if (p < 95) return $urandom_range(4095) - 2048;
      return p[0] ? 2047 : -2048;
   endfunction

   function automatic cmd_type pick_cmd();
      cmd_type c;
      int p;
      p = $urandom_range(99);
      c.mode = p < 20 ? MODE_LINE : p < 27 ? MODE_MOVE : p < 42 ? MODE_LINE_TO :
               p < 52 ? MODE_RECT : p < 60 ? MODE_FILL : p < 66 ? MODE_CLEAR_RECT :
               p < 68 ? MODE_CLEAR_ALL : MODE_READ;
      c.xa = coord(130); c.ya = coord(66);
      c.xb = coord(130); c.yb = coord(66);
      if (c.mode inside {MODE_FILL, MODE_CLEAR_RECT} && $urandom_range(3) != 0) begin
         c.xb = c.xa + $urandom_range(24) - 12;
         c.yb = c.ya + $urandom_range(24) - 12;
         c.xb = $signed(c.xb[CoordW-1:0]);
         c.yb = $signed(c.yb[CoordW-1:0]);
      end
      c.idx = $urandom_range(1) ? $urandom_range(1023) : $urandom_range(255);
      c.chk = 0;
      return c;
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            want = render(cur);
            if (cur.chk) begin
               want.rd = cur.rd[DataW-1:0];
               want.px = cur.px[CoordW-1:0];
               want.py = cur.py[CoordW-1:0];
            end
            pending.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            n_seen++;
            got.rd = rsp_if.read_data;
            got.px = rsp_if.current_pen_x;
            got.py = rsp_if.current_pen_y;
            if (pending.size() == 0) begin
               $error("unexpected result rd=%h pen=%h,%h", got.rd, got.px, got.py);
               errors++;
            end else begin
               want = pending.pop_front();
               if (got.rd !== want.rd) begin
                  $error("read_data expected %h actual %h", want.rd, got.rd);
                  errors++;
               end
               if (got.px !== want.px) begin
                  $error("current_pen_x expected %h actual %h", want.px, got.px);
                  errors++;
               end
               if (got.py !== want.py) begin
                  $error("current_pen_y expected %h actual %h", want.py, got.py);
                  errors++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("timeout: %0d results outstanding", pending.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   int stall_left, run_left;
   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
         rsp_if.ready <= 1'b1;
      end else if ($urandom_range(2) == 0) begin
         stall_left <= $urandom_range(14) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         run_left <= $urandom_range(40);
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic csr_write(logic [CsrAddrW-1:0] a, int v);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = a; pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (a == AddrWidth) reg_w = v & 8'hFF;
      else reg_h = v & 7'h7F;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send(cmd_type c);
      if (!calm && $urandom_range(5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(14, 1)) @(negedge clock);
      end
      cur = c;
      req_if.valid = 1'b1;
      req_if.mode = c.mode;
      req_if.x_a = c.xa[CoordW-1:0];
      req_if.y_a = c.ya[CoordW-1:0];
      req_if.x_b = c.xb[CoordW-1:0];
      req_if.y_b = c.yb[CoordW-1:0];
      req_if.byte_index = c.idx[IdxW-1:0];
      do @(posedge clock); while (!req_if.ready);
      n_sent++;
      @(negedge clock);
   endtask

   initial begin
      int widths[6]  = '{128, 1, 255, 0, 37, 128};
      int heights[6] = '{64, 8, 127, 64, 13, 64};
      req_if.valid = 1'b0;
      req_if.mode = MODE_LINE;
      req_if.x_a = '0; req_if.y_a = '0; req_if.x_b = '0; req_if.y_b = '0;
      req_if.byte_index = '0;
      rsp_if.ready = 1'b1;
      calm = 1'b0;
      foreach (pix_mem[i]) pix_mem[i] = '0;
      pen_x = 0; pen_y = 0; reg_w = 128; reg_h = 64;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      row(MODE_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      row(MODE_READ, 0, 0, 0, 0, 1023, 1, 0, 0, 0);
      row(MODE_MOVE, 0, 0, 2047, -2048, 0, 1, 0, 2047, -2048);
      row(MODE_MOVE, 5, 5, -2048, 2047, 0, 1, 0, -2048, 2047);
      row(MODE_MOVE, 0, 0, -1, 5, 0, 1, 0, -1, 5);
      row(MODE_LINE_TO, 0, 0, 10, 3, 0);
      row(MODE_LINE, 0, 0, 5, 5, 0);
      row(MODE_LINE, -2048, -2048, 2047, 2047, 0);
      row(MODE_LINE, 2047, 0, -2048, 63, 0);
      row(MODE_LINE, 3, 9, 3, 9, 0);
      row(MODE_LINE, 127, 0, 127, 63, 0);
      row(MODE_READ, 0, 0, 0, 0, 0);
      row(MODE_RECT, 20, 30, 4, 10, 0);
      row(MODE_RECT, 7, 7, 7, 7, 0);
      row(MODE_RECT, -2048, -2048, 2047, 2047, 0);
      row(MODE_READ, 0, 0, 0, 0, 1023);
      row(MODE_FILL, 2047, 2047, -2048, -2048, 0);
      row(MODE_READ, 0, 0, 0, 0, 1023, 1, 255, 10, 3);
      row(MODE_CLEAR_RECT, 0, 0, 8, 8, 0);
      row(MODE_READ, 0, 0, 0, 0, 7, 1, 0, 10, 3);
      row(MODE_CLEAR_ALL, 0, 0, 0, 0, 0);
      row(MODE_READ, 0, 0, 0, 0, 512, 1, 0, 10, 3);
      row(MODE_FILL, 126, 60, 200, 100, 0);
      row(MODE_READ, 0, 0, 0, 0, 1023);
      foreach (plan[i]) send(plan[i]);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(AddrWidth, widths[ph]);
         csr_write(AddrHeight, heights[ph]);
         if (ph == 5) calm = 1'b1;
         for (int k = 0; k < 215; k++) begin
            if (ph == 2 && k == 100) drain();
            send(pick_cmd());
         end
         drain();
      end

      repeat (50) @(negedge clock);
      $display("sent %0d commands over six bitmap sizes, %0d results checked",
               n_sent, n_seen);
      $display("all drawing modes, extreme coordinates and byte reads covered");
      if (errors == 0 && pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
